/* sv/obb_pkg.sv */
package obb_pkg;

   typedef enum logic [3:0] {
      MODE_U  = 4'd0,
      MODE_V  = 4'd1,
      MODE_W  = 4'd2,
      MODE_UV = 4'd3,
      MODE_UW = 4'd4,
      MODE_VU = 4'd5,
      MODE_VW = 4'd6,
      MODE_WU = 4'd7,
      MODE_WV = 4'd8
   } mode_type;

   localparam int MODE_W_BITS = 4;
   localparam int TAG_W       = MODE_W_BITS + 1;

   // 1/0.01^2 for the short cross product test
   localparam int THRESH_DIV = 10000;

   typedef struct packed {
      logic [MODE_W_BITS-1:0] mode;
      logic                   bad;
   } tag_type;

endpackage

/* sv/obb_cross.sv */
module obb_cross #(
   parameter int AW = 16,
   parameter int SW = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [AW-1:0] in_a [3],
   input  logic signed [AW-1:0] in_b [3],
   input  logic [SW-1:0]       in_side,
   output logic                out_valid,
   output logic signed [2*AW:0] out_c [3],
   output logic [SW-1:0]       out_side
);
   import obb_pkg::*;

   localparam int PW = 2 * AW;
   localparam int CW = 2 * AW + 1;

   logic signed [PW-1:0] pp_in [3];
   logic signed [PW-1:0] pn_in [3];
   logic signed [CW-1:0] c_in [3];
   logic                 v_ff;
   logic signed [CW-1:0] c_ff [3];
   logic [SW-1:0]        side_ff;

   always_comb begin
      pp_in[0] = PW'(in_a[1]) * PW'(in_b[2]);
      pn_in[0] = PW'(in_a[2]) * PW'(in_b[1]);
      pp_in[1] = PW'(in_a[2]) * PW'(in_b[0]);
      pn_in[1] = PW'(in_a[0]) * PW'(in_b[2]);
      pp_in[2] = PW'(in_a[0]) * PW'(in_b[1]);
      pn_in[2] = PW'(in_a[1]) * PW'(in_b[0]);
      for (int i = 0; i < 3; i++) begin
         c_in[i] = CW'(pp_in[i]) - CW'(pn_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            c_ff[i] <= c_in[i];
         end
         side_ff <= in_side;
      end
   end

   assign out_valid = v_ff;
   assign out_c     = c_ff;
   assign out_side  = side_ff;

endmodule

/* sv/obb_norm3.sv */
module obb_norm3 #(
   parameter int CW        = 16,
   parameter int SW        = 1,
   parameter int FRAC_BITS = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [CW-1:0]        in_vec [3],
   input  logic [SW-1:0]               in_side,
   output logic                        out_valid,
   output logic signed [FRAC_BITS+1:0] out_vec [3],
   output logic                        out_zero,
   output logic [SW-1:0]               out_side
);
   import obb_pkg::*;

   localparam int MW  = 24;
   localparam int LW  = 2 * MW + 2;
   localparam int RW  = MW + 1;
   localparam int RMW = RW + 3;
   localparam int DRW = RW + 2;
   localparam int QW  = FRAC_BITS + 1;
   localparam int NW  = MW + QW + 1;
   localparam int OW  = FRAC_BITS + 2;
   localparam int SHW = $clog2(CW + 1);
   localparam int XW  = CW + MW;
   localparam int TW  = SW + 4;
   localparam int KW  = 3 * MW + TW;

   // magnitudes
   logic            v0_ff;
   logic [CW-1:0]   mag0_ff [3];
   logic [2:0]      sgn0_ff;
   logic [SW-1:0]   side0_ff;

   // leading one
   logic [CW-1:0]   orv;
   logic [SHW-1:0]  sh1_in;
   logic            v1_ff;
   logic [CW-1:0]   mag1_ff [3];
   logic [2:0]      sgn1_ff;
   logic [SW-1:0]   side1_ff;
   logic [SHW-1:0]  sh1_ff;

   // aligned magnitudes
   logic [XW-1:0]   wide_in [3];
   logic            v2_ff;
   logic [MW-1:0]   m2_ff [3];
   logic [2:0]      sgn2_ff;
   logic            zero2_ff;
   logic [SW-1:0]   side2_ff;

   // squares
   logic            v3_ff;
   logic [2*MW-1:0] sq3_ff [3];
   logic [MW-1:0]   m3_ff [3];
   logic [2:0]      sgn3_ff;
   logic            zero3_ff;
   logic [SW-1:0]   side3_ff;

   // square root chain
   logic            sv_ff    [RW+1];
   logic [RMW-1:0]  srem_ff  [RW+1];
   logic [RW-1:0]   sroot_ff [RW+1];
   logic [LW-1:0]   slr_ff   [RW+1];
   logic [KW-1:0]   sk_ff    [RW+1];

   // divide chain
   logic [NW-1:0]   n_in [3];
   logic            dv_ff   [QW+1];
   logic [DRW-1:0]  drem_ff [QW+1][3];
   logic [QW-1:0]   dq_ff   [QW+1][3];
   logic [QW-1:0]   dn_ff   [QW+1][3];
   logic [RW-1:0]   ds_ff   [QW+1];
   logic [TW-1:0]   dk_ff   [QW+1];

   logic            ov_ff;
   logic signed [OW-1:0] ovec_ff [3];
   logic            ozero_ff;
   logic [SW-1:0]   oside_ff;
   logic [TW-1:0]   otag;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag0_ff[i] <= in_vec[i][CW-1] ? $unsigned(-in_vec[i]) : $unsigned(in_vec[i]);
            sgn0_ff[i] <= in_vec[i][CW-1];
         end
         side0_ff <= in_side;
      end
   end

   always_comb begin
      orv    = mag0_ff[0] | mag0_ff[1] | mag0_ff[2];
      sh1_in = '0;
      for (int i = 0; i < CW; i++) begin
         if (orv[i]) begin
            sh1_in = SHW'(i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
      if (en) begin
         mag1_ff  <= mag0_ff;
         sgn1_ff  <= sgn0_ff;
         side1_ff <= side0_ff;
         sh1_ff   <= sh1_in;
      end
   end

   // leading one lands on bit MW-1
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wide_in[i] = {mag1_ff[i], {MW{1'b0}}} >> sh1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            m2_ff[i] <= wide_in[i][MW-1:0];
         end
         sgn2_ff  <= sgn1_ff;
         zero2_ff <= (sh1_ff == '0);
         side2_ff <= side1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq3_ff[i] <= (2*MW)'(m2_ff[i]) * (2*MW)'(m2_ff[i]);
         end
         m3_ff    <= m2_ff;
         sgn3_ff  <= sgn2_ff;
         zero3_ff <= zero2_ff;
         side3_ff <= side2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (en) begin
         sv_ff[0] <= v3_ff;
      end
      if (en) begin
         srem_ff[0]  <= '0;
         sroot_ff[0] <= '0;
         slr_ff[0]   <= LW'(sq3_ff[0]) + LW'(sq3_ff[1]) + LW'(sq3_ff[2]);
         sk_ff[0]    <= {side3_ff, zero3_ff, sgn3_ff, m3_ff[0], m3_ff[1], m3_ff[2]};
      end
   end

   for (genvar j = 0; j < RW; j++) begin : g_sqrt
      logic [RMW-1:0] rs_in;
      logic [RMW-1:0] trial_in;
      logic [RMW-1:0] rem_in;
      logic [RW-1:0]  root_in;

      always_comb begin
         rs_in    = {srem_ff[j][RMW-3:0], slr_ff[j][LW-1 -: 2]};
         trial_in = RMW'({sroot_ff[j], 2'b01});
         if (rs_in >= trial_in) begin
            rem_in  = rs_in - trial_in;
            root_in = {sroot_ff[j][RW-2:0], 1'b1};
         end else begin
            rem_in  = rs_in;
            root_in = {sroot_ff[j][RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[j+1] <= 1'b0;
         end else if (en) begin
            sv_ff[j+1] <= sv_ff[j];
         end
         if (en) begin
            srem_ff[j+1]  <= rem_in;
            sroot_ff[j+1] <= root_in;
            slr_ff[j+1]   <= slr_ff[j] << 2;
            sk_ff[j+1]    <= sk_ff[j];
         end
      end
   end

   // rounded quotient: (m * 2^(F+1) + s) / (2s)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i] = (NW'(sk_ff[RW][(3-i)*MW-1 -: MW]) << QW) + NW'(sroot_ff[RW]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= sv_ff[RW];
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            drem_ff[0][i] <= DRW'(n_in[i] >> QW);
            dq_ff[0][i]   <= '0;
            dn_ff[0][i]   <= n_in[i][QW-1:0];
         end
         ds_ff[0] <= sroot_ff[RW];
         dk_ff[0] <= sk_ff[RW][KW-1 -: TW];
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [DRW-1:0] dd_in;
      logic [DRW-1:0] rs_in  [3];
      logic [DRW-1:0] rem_in [3];
      logic [QW-1:0]  q_in   [3];

      always_comb begin
         dd_in = {1'b0, ds_ff[k], 1'b0};
         for (int i = 0; i < 3; i++) begin
            rs_in[i] = {drem_ff[k][i][DRW-2:0], dn_ff[k][i][QW-1]};
            if (rs_in[i] >= dd_in) begin
               rem_in[i] = rs_in[i] - dd_in;
               q_in[i]   = {dq_ff[k][i][QW-2:0], 1'b1};
            end else begin
               rem_in[i] = rs_in[i];
               q_in[i]   = {dq_ff[k][i][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (en) begin
            dv_ff[k+1] <= dv_ff[k];
         end
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               drem_ff[k+1][i] <= rem_in[i];
               dq_ff[k+1][i]   <= q_in[i];
               dn_ff[k+1][i]   <= dn_ff[k][i] << 1;
            end
            ds_ff[k+1] <= ds_ff[k];
            dk_ff[k+1] <= dk_ff[k];
         end
      end
   end

   assign otag = dk_ff[QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= dv_ff[QW];
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (otag[3]) begin
               ovec_ff[i] <= '0;
            end else if (otag[i]) begin
               ovec_ff[i] <= -$signed(OW'(dq_ff[QW][i]));
            end else begin
               ovec_ff[i] <= $signed(OW'(dq_ff[QW][i]));
            end
         end
         ozero_ff <= otag[3];
         oside_ff <= otag[TW-1:4];
      end
   end

   assign out_valid = ov_ff;
   assign out_vec   = ovec_ff;
   assign out_zero  = ozero_ff;
   assign out_side  = oside_ff;

endmodule

/* sv/obb_perp.sv */
module obb_perp #(
   parameter int CC        = 33,
   parameter int FRAC_BITS = 14,
   parameter int CW2       = 33
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [FRAC_BITS+1:0] in_a [3],
   input  logic                        in_zero,
   input  logic [3:0]                  in_mode,
   input  logic signed [CC-1:0]        in_c [3],
   output logic                        out_valid,
   output logic signed [CW2-1:0]       out_vec [3],
   output obb_pkg::tag_type            out_tag,
   output logic signed [FRAC_BITS+1:0] out_a [3]
);
   import obb_pkg::*;

   localparam int OW  = FRAC_BITS + 2;
   localparam int SQW = 2 * OW;
   localparam logic [SQW-1:0] LIMIT =
      SQW'(((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'(THRESH_DIV));

   logic                 v1_ff;
   logic signed [OW-1:0] a1_ff [3];
   logic                 zero1_ff;
   logic [3:0]           mode1_ff;
   logic signed [CC-1:0] c1_ff [3];
   logic                 cz1_ff;
   logic [SQW-1:0]       sqy1_ff;
   logic [SQW-1:0]       sqz1_ff;

   logic                 short_in;
   logic signed [CW2-1:0] vec_in [3];
   tag_type              tag_in;

   logic                 v2_ff;
   logic signed [CW2-1:0] vec2_ff [3];
   tag_type              tag2_ff;
   logic signed [OW-1:0] a2_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         a1_ff    <= in_a;
         zero1_ff <= in_zero;
         mode1_ff <= in_mode;
         c1_ff    <= in_c;
         cz1_ff   <= (in_c[0] == '0) && (in_c[1] == '0) && (in_c[2] == '0);
         sqy1_ff  <= $unsigned(SQW'(in_a[1]) * SQW'(in_a[1]));
         sqz1_ff  <= $unsigned(SQW'(in_a[2]) * SQW'(in_a[2]));
      end
   end

   always_comb begin
      short_in    = (sqy1_ff + sqz1_ff) <= LIMIT;
      tag_in.mode = mode1_ff;
      tag_in.bad  = 1'b1;
      for (int i = 0; i < 3; i++) begin
         vec_in[i] = CW2'(c1_ff[i]);
      end
      case (mode1_ff) inside
         MODE_U, MODE_V, MODE_W: begin
            tag_in.bad = zero1_ff;
            if (short_in) begin
               vec_in[0] = -CW2'(a1_ff[2]);
               vec_in[1] = '0;
               vec_in[2] = CW2'(a1_ff[0]);
            end else begin
               vec_in[0] = '0;
               vec_in[1] = CW2'(a1_ff[2]);
               vec_in[2] = -CW2'(a1_ff[1]);
            end
         end
         MODE_UW, MODE_VU, MODE_WV: begin
            tag_in.bad = cz1_ff;
            for (int i = 0; i < 3; i++) begin
               vec_in[i] = -CW2'(c1_ff[i]);
            end
         end
         MODE_UV, MODE_VW, MODE_WU: begin
            tag_in.bad = cz1_ff;
         end
         default: begin
            tag_in.bad = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         vec2_ff <= vec_in;
         tag2_ff <= tag_in;
         a2_ff   <= a1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_vec   = vec2_ff;
   assign out_tag   = tag2_ff;
   assign out_a     = a2_ff;

endmodule

/* sv/orthonormal_basis_builder_core.sv */
// throughput: one word per cycle while the output is not stalled; three normalizer pipes
// in series, each with its 25-stage square root and FRAC_BITS+1-stage divider chains
// a stalled response freezes every stage and raises req_stall in the same cycle
// reset: synchronous, clears every valid bit; payload registers are not reset
module orthonormal_basis_builder_core #(
   parameter int IN_WIDTH  = 16,
   parameter int FRAC_BITS = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [3:0]                  req_type,
   input  logic signed [IN_WIDTH-1:0]  req_first_x,
   input  logic signed [IN_WIDTH-1:0]  req_first_y,
   input  logic signed [IN_WIDTH-1:0]  req_first_z,
   input  logic signed [IN_WIDTH-1:0]  req_second_x,
   input  logic signed [IN_WIDTH-1:0]  req_second_y,
   input  logic signed [IN_WIDTH-1:0]  req_second_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [FRAC_BITS+1:0] rsp_u_x,
   output logic signed [FRAC_BITS+1:0] rsp_u_y,
   output logic signed [FRAC_BITS+1:0] rsp_u_z,
   output logic signed [FRAC_BITS+1:0] rsp_v_x,
   output logic signed [FRAC_BITS+1:0] rsp_v_y,
   output logic signed [FRAC_BITS+1:0] rsp_v_z,
   output logic signed [FRAC_BITS+1:0] rsp_w_x,
   output logic signed [FRAC_BITS+1:0] rsp_w_y,
   output logic signed [FRAC_BITS+1:0] rsp_w_z,
   output logic                        rsp_degenerate
);
   import obb_pkg::*;

   localparam int OW  = FRAC_BITS + 2;
   localparam int CC  = 2 * IN_WIDTH + 1;
   localparam int CW2 = (CC > OW) ? CC : OW;
   localparam int CW3 = 2 * OW + 1;
   localparam int S0W = MODE_W_BITS + 3 * IN_WIDTH;
   localparam int S1W = MODE_W_BITS + 3 * CC;
   localparam int S2W = TAG_W + 3 * OW;
   localparam int S3W = TAG_W + 6 * OW;

   logic                       en;

   logic signed [IN_WIDTH-1:0] p_vec [3];
   logic signed [IN_WIDTH-1:0] q_vec [3];
   logic                       f_v;
   logic signed [CC-1:0]       f_c [3];
   logic [S0W-1:0]             f_side;
   logic signed [IN_WIDTH-1:0] f_p [3];

   logic                       n1_v;
   logic signed [OW-1:0]       n1_a [3];
   logic                       n1_zero;
   logic [S1W-1:0]             n1_side;
   logic signed [CC-1:0]       n1_c [3];

   logic                       pp_v;
   logic signed [CW2-1:0]      pp_vec [3];
   tag_type                    pp_tag;
   logic signed [OW-1:0]       pp_a [3];

   logic                       n2_v;
   logic signed [OW-1:0]       n2_b [3];
   logic [S2W-1:0]             n2_side;
   tag_type                    tag2;
   logic signed [OW-1:0]       a2 [3];
   logic signed [OW-1:0]       xa_in [3];
   logic signed [OW-1:0]       xb_in [3];

   logic                       x_v;
   logic signed [CW3-1:0]      x_c [3];
   logic [S3W-1:0]             x_side;

   logic                       n3_v;
   logic signed [OW-1:0]       n3_t [3];
   logic [S3W-1:0]             n3_side;
   tag_type                    tag3;
   logic signed [OW-1:0]       a3 [3];
   logic signed [OW-1:0]       b3 [3];

   logic signed [OW-1:0]       u_in [3];
   logic signed [OW-1:0]       v_in [3];
   logic signed [OW-1:0]       w_in [3];

   logic                       rsp_valid_ff;
   logic signed [OW-1:0]       u_ff [3];
   logic signed [OW-1:0]       v_ff [3];
   logic signed [OW-1:0]       w_ff [3];
   logic                       degen_ff;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   assign p_vec[0] = req_first_x;
   assign p_vec[1] = req_first_y;
   assign p_vec[2] = req_first_z;
   assign q_vec[0] = req_second_x;
   assign q_vec[1] = req_second_y;
   assign q_vec[2] = req_second_z;

   obb_cross #(.AW(IN_WIDTH), .SW(S0W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_a      (p_vec),
      .in_b      (q_vec),
      .in_side   ({req_type, req_first_x, req_first_y, req_first_z}),
      .out_valid (f_v),
      .out_c     (f_c),
      .out_side  (f_side)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f_p[i]  = $signed(f_side[(3-i)*IN_WIDTH-1 -: IN_WIDTH]);
         n1_c[i] = $signed(n1_side[(3-i)*CC-1 -: CC]);
      end
   end

   obb_norm3 #(.CW(IN_WIDTH), .SW(S1W), .FRAC_BITS(FRAC_BITS)) u_norm_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_v),
      .in_vec    (f_p),
      .in_side   ({f_side[S0W-1 -: MODE_W_BITS], f_c[0], f_c[1], f_c[2]}),
      .out_valid (n1_v),
      .out_vec   (n1_a),
      .out_zero  (n1_zero),
      .out_side  (n1_side)
   );

   obb_perp #(.CC(CC), .FRAC_BITS(FRAC_BITS), .CW2(CW2)) u_perp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (n1_v),
      .in_a      (n1_a),
      .in_zero   (n1_zero),
      .in_mode   (n1_side[S1W-1 -: MODE_W_BITS]),
      .in_c      (n1_c),
      .out_valid (pp_v),
      .out_vec   (pp_vec),
      .out_tag   (pp_tag),
      .out_a     (pp_a)
   );

   obb_norm3 #(.CW(CW2), .SW(S2W), .FRAC_BITS(FRAC_BITS)) u_norm_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pp_v),
      .in_vec    (pp_vec),
      .in_side   ({pp_tag, pp_a[0], pp_a[1], pp_a[2]}),
      .out_valid (n2_v),
      .out_vec   (n2_b),
      .out_zero  (),
      .out_side  (n2_side)
   );

   // MODE_V and the pair modes UV, VW, WU take the third vector as B x A
   always_comb begin
      tag2 = tag_type'(n2_side[S2W-1 -: TAG_W]);
      for (int i = 0; i < 3; i++) begin
         a2[i] = $signed(n2_side[(3-i)*OW-1 -: OW]);
      end
      case (tag2.mode) inside
         MODE_V, MODE_UV, MODE_VW, MODE_WU: begin
            xa_in = n2_b;
            xb_in = a2;
         end
         default: begin
            xa_in = a2;
            xb_in = n2_b;
         end
      endcase
   end

   obb_cross #(.AW(OW), .SW(S3W)) u_third (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (n2_v),
      .in_a      (xa_in),
      .in_b      (xb_in),
      .in_side   ({tag2, a2[0], a2[1], a2[2], n2_b[0], n2_b[1], n2_b[2]}),
      .out_valid (x_v),
      .out_c     (x_c),
      .out_side  (x_side)
   );

   obb_norm3 #(.CW(CW3), .SW(S3W), .FRAC_BITS(FRAC_BITS)) u_norm_c (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (x_v),
      .in_vec    (x_c),
      .in_side   (x_side),
      .out_valid (n3_v),
      .out_vec   (n3_t),
      .out_zero  (),
      .out_side  (n3_side)
   );

   always_comb begin
      tag3 = tag_type'(n3_side[S3W-1 -: TAG_W]);
      for (int i = 0; i < 3; i++) begin
         a3[i] = $signed(n3_side[(6-i)*OW-1 -: OW]);
         b3[i] = $signed(n3_side[(3-i)*OW-1 -: OW]);
      end
      u_in = a3;
      v_in = b3;
      w_in = n3_t;
      case (tag3.mode) inside
         MODE_U, MODE_UW: begin
            u_in = a3;   v_in = b3;   w_in = n3_t;
         end
         MODE_V, MODE_VW: begin
            u_in = b3;   v_in = a3;   w_in = n3_t;
         end
         MODE_W, MODE_WV: begin
            u_in = b3;   v_in = n3_t; w_in = a3;
         end
         MODE_UV: begin
            u_in = a3;   v_in = n3_t; w_in = b3;
         end
         MODE_VU: begin
            u_in = n3_t; v_in = a3;   w_in = b3;
         end
         MODE_WU: begin
            u_in = n3_t; v_in = b3;   w_in = a3;
         end
         default: begin
            u_in = a3;   v_in = b3;   w_in = n3_t;
         end
      endcase
      if (tag3.bad) begin
         for (int i = 0; i < 3; i++) begin
            u_in[i] = '0;
            v_in[i] = '0;
            w_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= n3_v;
      end
      if (en) begin
         u_ff     <= u_in;
         v_ff     <= v_in;
         w_ff     <= w_in;
         degen_ff <= tag3.bad;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_u_x        = u_ff[0];
   assign rsp_u_y        = u_ff[1];
   assign rsp_u_z        = u_ff[2];
   assign rsp_v_x        = v_ff[0];
   assign rsp_v_y        = v_ff[1];
   assign rsp_v_z        = v_ff[2];
   assign rsp_w_x        = w_ff[0];
   assign rsp_w_y        = w_ff[1];
   assign rsp_w_z        = w_ff[2];
   assign rsp_degenerate = degen_ff;

endmodule

/* sv/obb_checker.sv */
module obb_checker #(
   parameter int IN_WIDTH  = 16,
   parameter int FRAC_BITS = 14
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [3:0]                  req_type,
   input logic signed [IN_WIDTH-1:0]  req_first_x,
   input logic signed [IN_WIDTH-1:0]  req_first_y,
   input logic signed [IN_WIDTH-1:0]  req_first_z,
   input logic signed [IN_WIDTH-1:0]  req_second_x,
   input logic signed [IN_WIDTH-1:0]  req_second_y,
   input logic signed [IN_WIDTH-1:0]  req_second_z,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [FRAC_BITS+1:0] rsp_u_x,
   input logic signed [FRAC_BITS+1:0] rsp_u_y,
   input logic signed [FRAC_BITS+1:0] rsp_u_z,
   input logic signed [FRAC_BITS+1:0] rsp_v_x,
   input logic signed [FRAC_BITS+1:0] rsp_v_y,
   input logic signed [FRAC_BITS+1:0] rsp_v_z,
   input logic signed [FRAC_BITS+1:0] rsp_w_x,
   input logic signed [FRAC_BITS+1:0] rsp_w_y,
   input logic signed [FRAC_BITS+1:0] rsp_w_z,
   input logic                        rsp_degenerate
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_u_x) && $stable(rsp_v_y)
         && $stable(rsp_w_z) && $stable(rsp_degenerate))
      else $error("stalled response word changed");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_u_x == '0 && rsp_u_y == '0 && rsp_u_z == '0
         && rsp_v_x == '0 && rsp_v_y == '0 && rsp_v_z == '0
         && rsp_w_x == '0 && rsp_w_y == '0 && rsp_w_z == '0)
      else $error("degenerate word with nonzero basis");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while output free");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind orthonormal_basis_builder_core obb_checker #(
   .IN_WIDTH  (IN_WIDTH),
   .FRAC_BITS (FRAC_BITS)
) u_obb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_type       (req_type),
   .req_first_x    (req_first_x),
   .req_first_y    (req_first_y),
   .req_first_z    (req_first_z),
   .req_second_x   (req_second_x),
   .req_second_y   (req_second_y),
   .req_second_z   (req_second_z),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_u_x        (rsp_u_x),
   .rsp_u_y        (rsp_u_y),
   .rsp_u_z        (rsp_u_z),
   .rsp_v_x        (rsp_v_x),
   .rsp_v_y        (rsp_v_y),
   .rsp_v_z        (rsp_v_z),
   .rsp_w_x        (rsp_w_x),
   .rsp_w_y        (rsp_w_y),
   .rsp_w_z        (rsp_w_z),
   .rsp_degenerate (rsp_degenerate)
);
